@@ hw/rtl/bkv_pkg.sv @@
// shared types, constants and key tables for the bracket key/value text parser
// no dependencies; used by all rtl modules
package bkv_pkg;

  localparam int MAX_VALUE_LEN = 128;
  localparam int MAX_NAME_LEN  = 64;
  localparam int STAGE_LIMIT   = 128;
  localparam int COUNT_CAP     = (MAX_VALUE_LEN > 255) ? 255 : MAX_VALUE_LEN;

  localparam int NAME_POS_W  = $clog2(MAX_NAME_LEN + 2);
  localparam int VALUE_CNT_W = 8;

  localparam int KEY_COUNT = 5;
  localparam int KEY_LEN   = 12;
  localparam int KEY_IDX_W = 3;
  localparam logic [KEY_IDX_W-1:0] KEY_NONE = 3'd7;

  // special bytes
  localparam logic [7:0] CH_NAME_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_NAME_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_VALUE_OPEN = 8'h3C;  // <
  localparam logic [7:0] CH_COMMIT     = 8'h3E;  // >
  localparam logic [7:0] CH_ZERO       = 8'h00;

  localparam logic KIND_STAGE  = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  localparam logic [1:0] TARGET_NAME   = 2'd0;
  localparam logic [1:0] TARGET_SERIAL = 2'd1;
  localparam logic [1:0] TARGET_MAC    = 2'd2;
  localparam logic [1:0] TARGET_OID    = 2'd3;

  localparam logic [7:0] KEY_CHARS [KEY_COUNT][KEY_LEN] = '{
    '{"A", "L", "I", "A", "S", "_", "N", "A", "M", "E", 8'h00, 8'h00},
    '{"P", "R", "O", "D", "U", "C", "T", "_", "N", "A", "M", "E"},
    '{"S", "E", "R", "I", "A", "L", "_", "N", "O", 8'h00, 8'h00, 8'h00},
    '{"M", "A", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"O", "I", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [NAME_POS_W-1:0] KEY_SIZE [KEY_COUNT] = '{
    NAME_POS_W'(10), NAME_POS_W'(12), NAME_POS_W'(9), NAME_POS_W'(3), NAME_POS_W'(3)
  };
  localparam logic [1:0] KEY_TARGET [KEY_COUNT] = '{
    TARGET_NAME, TARGET_NAME, TARGET_SERIAL, TARGET_MAC, TARGET_OID
  };
  localparam logic [VALUE_CNT_W-1:0] KEY_LIMIT [KEY_COUNT] = '{
    VALUE_CNT_W'(24), VALUE_CNT_W'(24), VALUE_CNT_W'(31), VALUE_CNT_W'(12),
    VALUE_CNT_W'(128)
  };

  typedef struct packed {
    logic       result_kind;
    logic [6:0] stage_index;
    logic [7:0] stage_byte;
    logic [1:0] target_field;
    logic [7:0] commit_length;
  } bkv_result_t;

  // key character at a name position, zero past the stored key text
  function automatic logic [7:0] key_char(input int k, input logic [NAME_POS_W-1:0] pos);
    logic [7:0] c;
    c = 8'h00;
    if (pos < NAME_POS_W'(KEY_LEN)) begin
      c = KEY_CHARS[k][pos[3:0]];
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/bkv_text_if.sv @@
// input channel of the parser: one record byte and the record start flag
// depends on nothing but the handshake convention valid/ready
interface bkv_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       record_start;

  modport source (output valid, output text_byte, output record_start, input ready);
  modport sink   (input valid, input text_byte, input record_start, output ready);
endinterface

@@ hw/rtl/bkv_result_if.sv @@
// output channel of the parser: one staged byte or one commit per transfer
// depends on nothing but the handshake convention valid/ready
interface bkv_result_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [6:0] stage_index;
  logic [7:0] stage_byte;
  logic [1:0] target_field;
  logic [7:0] commit_length;

  modport source (output valid, output result_kind, output stage_index, output stage_byte,
                  output target_field, output commit_length, input ready);
  modport sink   (input valid, input result_kind, input stage_index, input stage_byte,
                  input target_field, input commit_length, output ready);
endinterface

@@ hw/rtl/bkv_scan.sv @@
// parse state registers and the per-byte next-state and result logic
// depends on bkv_pkg
module bkv_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           text_byte,
  input  logic                 record_start,
  output logic                 has_result,
  output bkv_pkg::bkv_result_t result
);

  typedef struct packed {
    logic                                   name_open;
    logic                                   name_complete;
    logic [bkv_pkg::NAME_POS_W-1:0]         name_position;
    logic                                   name_ended_by_zero;
    logic [bkv_pkg::KEY_COUNT-1:0]          key_prefix_ok;
    logic [bkv_pkg::KEY_IDX_W-1:0]          latched_key;
    logic                                   value_open;
    logic [bkv_pkg::VALUE_CNT_W-1:0]        value_count;
  } scan_state_t;

  localparam scan_state_t STATE_CLEAR = '{
    name_open:          1'b0,
    name_complete:      1'b0,
    name_position:      '0,
    name_ended_by_zero: 1'b0,
    key_prefix_ok:      '1,
    latched_key:        bkv_pkg::KEY_NONE,
    value_open:         1'b0,
    value_count:        '0
  };

  scan_state_t state;
  scan_state_t state_next;
  scan_state_t cur;
  scan_state_t fed;
  logic [bkv_pkg::KEY_IDX_W-1:0] latch_key;
  logic [bkv_pkg::VALUE_CNT_W-1:0] limit;

  // name bytes narrow the set of keys still matching
  always_comb begin
    fed = cur;
    if (!cur.name_ended_by_zero) begin
      for (int k = 0; k < bkv_pkg::KEY_COUNT; k++) begin
        if (text_byte == bkv_pkg::CH_ZERO) begin
          if (bkv_pkg::KEY_SIZE[k] != cur.name_position) fed.key_prefix_ok[k] = 1'b0;
        end else begin
          if (!((cur.name_position < bkv_pkg::KEY_SIZE[k]) &&
                (bkv_pkg::key_char(k, cur.name_position) == text_byte))) begin
            fed.key_prefix_ok[k] = 1'b0;
          end
        end
      end
      if (text_byte == bkv_pkg::CH_ZERO) fed.name_ended_by_zero = 1'b1;
    end
    if (cur.name_position <= bkv_pkg::NAME_POS_W'(bkv_pkg::MAX_NAME_LEN)) begin
      fed.name_position = cur.name_position + 1'b1;
    end
  end

  // first key that is still a match for the name seen so far
  always_comb begin
    latch_key = bkv_pkg::KEY_NONE;
    if (cur.name_position <= bkv_pkg::NAME_POS_W'(bkv_pkg::MAX_NAME_LEN)) begin
      for (int k = bkv_pkg::KEY_COUNT - 1; k >= 0; k--) begin
        if (cur.key_prefix_ok[k] &&
            (cur.name_ended_by_zero || bkv_pkg::KEY_SIZE[k] == cur.name_position)) begin
          latch_key = bkv_pkg::KEY_IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    cur = record_start ? STATE_CLEAR : state;
    state_next = cur;
    has_result = 1'b0;
    result = '0;
    limit = '0;
    if (cur.latched_key < bkv_pkg::KEY_IDX_W'(bkv_pkg::KEY_COUNT)) begin
      limit = bkv_pkg::KEY_LIMIT[cur.latched_key];
    end
    case (text_byte)
      bkv_pkg::CH_NAME_OPEN: begin
        state_next = STATE_CLEAR;
        state_next.name_open = 1'b1;
      end
      bkv_pkg::CH_COMMIT: begin
        if (cur.name_complete && cur.value_open &&
            cur.latched_key < bkv_pkg::KEY_IDX_W'(bkv_pkg::KEY_COUNT)) begin
          has_result = 1'b1;
          result.result_kind = bkv_pkg::KIND_COMMIT;
          result.target_field = bkv_pkg::KEY_TARGET[cur.latched_key];
          result.commit_length = (cur.value_count > limit) ? limit : cur.value_count;
        end
        state_next = STATE_CLEAR;
      end
      bkv_pkg::CH_VALUE_OPEN: begin
        if (cur.name_open) state_next = fed;
        if (cur.name_complete) begin
          state_next.value_open = 1'b1;
          state_next.value_count = '0;
        end
      end
      default: begin
        if (cur.name_open) state_next = fed;
        if (text_byte == bkv_pkg::CH_NAME_CLOSE) begin
          // a close with no open name drops the latched name
          state_next.name_complete = cur.name_open;
          state_next.latched_key = cur.name_open ? latch_key : bkv_pkg::KEY_NONE;
        end
        if (cur.value_open) begin
          if (cur.value_count < bkv_pkg::VALUE_CNT_W'(bkv_pkg::STAGE_LIMIT) &&
              cur.value_count < bkv_pkg::VALUE_CNT_W'(bkv_pkg::MAX_VALUE_LEN)) begin
            has_result = 1'b1;
            result.result_kind = bkv_pkg::KIND_STAGE;
            result.stage_index = cur.value_count[6:0];
            result.stage_byte = text_byte;
          end
          if (cur.value_count < bkv_pkg::VALUE_CNT_W'(bkv_pkg::COUNT_CAP)) begin
            state_next.value_count = cur.value_count + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (take) begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/bracket_key_value_text_parser_core.sv @@
// top level of the bracket key/value text parser: scanner plus two-entry result queue
// depends on bkv_pkg, bkv_text_if, bkv_result_if and bkv_scan
//
// Scans a stored information record one byte per transfer for text of the form
// [KEY]=<value> with five keys: the alias name, the product name, the serial number,
// MAC and OID.
// Each value byte (positions 0 to 127) comes out as a staged-byte result with its
// index; '>' after a matched key gives one commit result naming the target (name,
// serial, MAC, OID) and the length already cut to that target's limit (24, 31, 12,
// 128). '[' cancels a pending value; names longer than 64 bytes match nothing.
// Setting record_start with a byte clears all parse state before that byte.
// Every byte is handled in the cycle it is taken: the parse state is updated at
// the input transfer and any result is written into a two-entry output queue, so
// one byte is taken every cycle while the queue has a free entry. The input
// only stalls when both queue entries hold results the consumer has not taken.
module bracket_key_value_text_parser_core (
  input  logic         clk,
  input  logic         rst,
  bkv_text_if.sink     text_chan,
  bkv_result_if.source result_chan
);

  logic                 take;
  logic                 has_result;
  bkv_pkg::bkv_result_t result;

  // output queue: q0 is the head shown on the port, q1 holds a result behind it
  logic [1:0]           cnt;
  logic [1:0]           cnt_next;
  bkv_pkg::bkv_result_t q0;
  bkv_pkg::bkv_result_t q1;
  logic                 push;
  logic                 pop;

  assign text_chan.ready = (cnt != 2'd2);
  assign take = text_chan.valid && text_chan.ready;

  bkv_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .text_byte    (text_chan.text_byte),
    .record_start (text_chan.record_start),
    .has_result   (has_result),
    .result       (result)
  );

  assign push = take && has_result;
  assign pop  = result_chan.valid && result_chan.ready;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) cnt_next = cnt + 2'd1;
    if (!push && pop) cnt_next = cnt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      q0 <= q1;
    end
    if (push) begin
      // the new result lands in the first free slot after this cycle's transfer out
      if (cnt == 2'd0 || (cnt == 2'd1 && pop)) begin
        q0 <= result;
      end else begin
        q1 <= result;
      end
    end
  end

  assign result_chan.valid         = (cnt != 2'd0);
  assign result_chan.result_kind   = q0.result_kind;
  assign result_chan.stage_index   = q0.stage_index;
  assign result_chan.stage_byte    = q0.stage_byte;
  assign result_chan.target_field  = q0.target_field;
  assign result_chan.commit_length = q0.commit_length;

endmodule

@@ hw/rtl/bkv_checker.sv @@
// port-level checks for the bracket key/value text parser, bound to its top level
// depends on bkv_pkg and bracket_key_value_text_parser_core
module bkv_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [6:0] stage_index,
  input logic [7:0] stage_byte,
  input logic [1:0] target_field,
  input logic [7:0] commit_length
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a staged byte carries no target and no length
  a_stage_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == bkv_pkg::KIND_STAGE) |->
      (target_field == bkv_pkg::TARGET_NAME && commit_length == 8'd0))
    else $error("staged byte with commit fields set");

  // a commit carries no staged byte and respects its target limit
  a_commit_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == bkv_pkg::KIND_COMMIT) |->
      (stage_index == 7'd0 && stage_byte == 8'd0 &&
       (target_field != bkv_pkg::TARGET_NAME   || commit_length <= 8'd24) &&
       (target_field != bkv_pkg::TARGET_SERIAL || commit_length <= 8'd31) &&
       (target_field != bkv_pkg::TARGET_MAC    || commit_length <= 8'd12) &&
       commit_length <= 8'd128))
    else $error("commit length beyond target limit");

  // a result that is not taken stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind bracket_key_value_text_parser_core bkv_checker u_bkv_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_chan.valid),
  .out_ready     (result_chan.ready),
  .result_kind   (result_chan.result_kind),
  .stage_index   (result_chan.stage_index),
  .stage_byte    (result_chan.stage_byte),
  .target_field  (result_chan.target_field),
  .commit_length (result_chan.commit_length)
);

@@ tb/bracket_key_value_text_parser_core_tb.sv @@
// testbench for bracket_key_value_text_parser_core: directed table, then random records
// depends on bkv_pkg, bkv_text_if, bkv_result_if and the parser rtl
`timescale 1ns / 1ps

module bracket_key_value_text_parser_core_tb;

  localparam int RANDOM_ITEMS  = 900;
  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on either side
  localparam int DRAIN_CYCLES  = 8;
  localparam int DIRECTED_ROWS = 24;

  // how a stimulus row gets its expectation
  typedef enum logic [1:0] {
    CHK_MODEL,  // from the scanner prediction
    CHK_NONE,   // no result
    CHK_GIVEN   // the result typed into the row
  } row_check_t;

  typedef struct packed {
    logic [7:0]           text_byte;
    logic                 record_start;
    logic                 hold;  // wait for all outstanding results before sending
    row_check_t           check;
    bkv_pkg::bkv_result_t given;
  } text_item_t;

  localparam bkv_pkg::bkv_result_t NO_RES = '0;

  localparam text_item_t DIRECTED [DIRECTED_ROWS] = '{
    // first byte after reset, record start set: open a name
    '{bkv_pkg::CH_NAME_OPEN, 1'b1, 1'b0, CHK_NONE, NO_RES},
    '{"M", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{"A", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{"C", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{bkv_pkg::CH_NAME_CLOSE, 1'b0, 1'b0, CHK_NONE, NO_RES},
    '{bkv_pkg::CH_VALUE_OPEN, 1'b0, 1'b0, CHK_NONE, NO_RES},
    // empty value under a matched key
    '{bkv_pkg::CH_COMMIT, 1'b0, 1'b0, CHK_GIVEN,
      '{bkv_pkg::KIND_COMMIT, 7'd0, 8'h00, bkv_pkg::TARGET_MAC, 8'd0}},
    // stray close, then commit with nothing open
    '{bkv_pkg::CH_NAME_CLOSE, 1'b0, 1'b0, CHK_NONE, NO_RES},
    '{bkv_pkg::CH_COMMIT, 1'b0, 1'b0, CHK_NONE, NO_RES},
    '{bkv_pkg::CH_NAME_OPEN, 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{"O", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{"I", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{"D", 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{bkv_pkg::CH_NAME_CLOSE, 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{bkv_pkg::CH_VALUE_OPEN, 1'b0, 1'b0, CHK_MODEL, NO_RES},
    // value byte extremes, and a close bracket staged as data
    '{8'h00, 1'b0, 1'b0, CHK_GIVEN,
      '{bkv_pkg::KIND_STAGE, 7'd0, 8'h00, bkv_pkg::TARGET_NAME, 8'd0}},
    '{8'hFF, 1'b0, 1'b0, CHK_GIVEN,
      '{bkv_pkg::KIND_STAGE, 7'd1, 8'hFF, bkv_pkg::TARGET_NAME, 8'd0}},
    '{bkv_pkg::CH_NAME_CLOSE, 1'b0, 1'b0, CHK_GIVEN,
      '{bkv_pkg::KIND_STAGE, 7'd2, bkv_pkg::CH_NAME_CLOSE, bkv_pkg::TARGET_NAME, 8'd0}},
    // restart the value
    '{bkv_pkg::CH_VALUE_OPEN, 1'b0, 1'b0, CHK_NONE, NO_RES},
    '{"A", 1'b0, 1'b0, CHK_GIVEN,
      '{bkv_pkg::KIND_STAGE, 7'd0, "A", bkv_pkg::TARGET_NAME, 8'd0}},
    // the later close latched a longer name, so this commit is left to the prediction
    '{bkv_pkg::CH_COMMIT, 1'b0, 1'b0, CHK_MODEL, NO_RES},
    // record start on a plain byte
    '{8'h7E, 1'b1, 1'b0, CHK_NONE, NO_RES},
    // commit with a name opened but never closed
    '{bkv_pkg::CH_NAME_OPEN, 1'b0, 1'b0, CHK_MODEL, NO_RES},
    '{bkv_pkg::CH_COMMIT, 1'b0, 1'b0, CHK_NONE, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  bkv_text_if   text_chan ();
  bkv_result_if result_chan ();

  bracket_key_value_text_parser_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .text_chan   (text_chan),
    .result_chan (result_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t           stim [$];
  bkv_pkg::bkv_result_t expected_results [$];

  int send_idx    = 0;
  int fail_count  = 0;
  int idle_cycles = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int ready_mode  = 0;
  int ready_left  = 0;
  int stall_phase = 0;

  // scanner state kept by the prediction
  bit       pn_open;
  bit       pn_done;
  int       pn_pos;
  bit       pn_zero;
  bit [4:0] pn_prefix;
  int       pn_key;
  bit       pv_open;
  int       pv_count;

  // key tables
  function automatic int key_len_of(input int k);
    case (k)
      0:       return 10;
      1:       return 12;
      2:       return 9;
      default: return 3;
    endcase
  endfunction

  function automatic logic [95:0] key_text_of(input int k);
    case (k)
      0:       return {"ALIAS", "_NAME"};
      1:       return {"PRODUCT", "_NAME"};
      2:       return {"SERIAL", "_NO"};
      3:       return "MAC";
      default: return "OID";
    endcase
  endfunction

  function automatic logic [1:0] key_target_of(input int k);
    case (k)
      0, 1:    return bkv_pkg::TARGET_NAME;
      2:       return bkv_pkg::TARGET_SERIAL;
      3:       return bkv_pkg::TARGET_MAC;
      default: return bkv_pkg::TARGET_OID;
    endcase
  endfunction

  function automatic int key_limit_of(input int k);
    case (k)
      0, 1:    return 24;
      2:       return 31;
      3:       return 12;
      default: return 128;
    endcase
  endfunction

  // letter p of key k, p below the key length
  function automatic logic [7:0] key_letter(input int k, input int p);
    logic [95:0] t;
    t = key_text_of(k) >> (8 * (key_len_of(k) - 1 - p));
    return t[7:0];
  endfunction

  task automatic clear_parse();
    pn_open   = 1'b0;
    pn_done   = 1'b0;
    pn_pos    = 0;
    pn_zero   = 1'b0;
    pn_prefix = 5'h1F;
    pn_key    = bkv_pkg::KEY_NONE;
    pv_open   = 1'b0;
    pv_count  = 0;
  endtask

  task automatic feed_name(input logic [7:0] b);
    bit keep;
    if (!pn_zero) begin
      for (int k = 0; k < bkv_pkg::KEY_COUNT; k++) begin
        if (b == bkv_pkg::CH_ZERO) begin
          keep = (key_len_of(k) == pn_pos);
        end else begin
          keep = (pn_pos < key_len_of(k)) && (key_letter(k, pn_pos) == b);
        end
        if (!keep) pn_prefix[k] = 1'b0;
      end
      if (b == bkv_pkg::CH_ZERO) pn_zero = 1'b1;
    end
    if (pn_pos <= bkv_pkg::MAX_NAME_LEN) pn_pos++;
  endtask

  // first key still matching the name seen so far, or none
  function automatic int name_key();
    int found;
    found = bkv_pkg::KEY_NONE;
    if (pn_pos <= bkv_pkg::MAX_NAME_LEN) begin
      for (int k = bkv_pkg::KEY_COUNT - 1; k >= 0; k--) begin
        if (pn_prefix[k] && (pn_zero || key_len_of(k) == pn_pos)) found = k;
      end
    end
    return found;
  endfunction

  // predicted scanner step for one byte
  task automatic parse_byte(input logic [7:0] b, input logic start, output bit has,
                            output bkv_pkg::bkv_result_t res);
    int lim;
    has = 1'b0;
    res = '0;
    if (start) clear_parse();
    if (b == bkv_pkg::CH_NAME_OPEN) begin
      clear_parse();
      pn_open = 1'b1;
    end else if (b == bkv_pkg::CH_COMMIT) begin
      if (pn_done && pv_open && pn_key < bkv_pkg::KEY_COUNT) begin
        lim               = key_limit_of(pn_key);
        has               = 1'b1;
        res.result_kind   = bkv_pkg::KIND_COMMIT;
        res.target_field  = key_target_of(pn_key);
        res.commit_length = 8'((pv_count > lim) ? lim : pv_count);
      end
      clear_parse();
    end else if (b == bkv_pkg::CH_VALUE_OPEN) begin
      if (pn_open) feed_name(b);
      if (pn_done) begin
        pv_open  = 1'b1;
        pv_count = 0;
      end
    end else begin
      if (b == bkv_pkg::CH_NAME_CLOSE) begin
        if (pn_open) begin
          pn_key  = name_key();
          pn_done = 1'b1;
        end else begin
          pn_done = 1'b0;
          pn_key  = bkv_pkg::KEY_NONE;
        end
      end
      if (pn_open) feed_name(b);
      if (pv_open) begin
        if (pv_count < bkv_pkg::STAGE_LIMIT && pv_count < bkv_pkg::MAX_VALUE_LEN) begin
          has             = 1'b1;
          res.result_kind = bkv_pkg::KIND_STAGE;
          res.stage_index = 7'(pv_count);
          res.stage_byte  = b;
        end
        if (pv_count < bkv_pkg::COUNT_CAP) pv_count++;
      end
    end
  endtask

  task automatic add_byte(input logic [7:0] b, input logic start);
    text_item_t item;
    item              = '0;
    item.text_byte    = b;
    item.record_start = start;
    item.check        = CHK_MODEL;
    stim.push_back(item);
  endtask

  // any byte that keeps a name open
  function automatic logic [7:0] name_filler();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == bkv_pkg::CH_NAME_OPEN || b == bkv_pkg::CH_COMMIT);
    return b;
  endfunction

  // any byte that stays inside an open value
  function automatic logic [7:0] value_filler();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == bkv_pkg::CH_NAME_OPEN || b == bkv_pkg::CH_VALUE_OPEN ||
           b == bkv_pkg::CH_COMMIT);
    return b;
  endfunction

  // one record, mostly well formed with random content
  task automatic add_record();
    int k;
    int n;
    int r;
    k = $urandom_range(0, bkv_pkg::KEY_COUNT - 1);
    if ($urandom_range(0, 9) == 0) begin
      // noise: any byte, record start now and then
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) add_byte(8'($urandom), $urandom_range(0, 15) == 0);
    end else begin
      add_byte(bkv_pkg::CH_NAME_OPEN, $urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        5: begin
          // zero-ended key with trailing junk
          for (int i = 0; i < key_len_of(k); i++) add_byte(key_letter(k, i), 1'b0);
          add_byte(bkv_pkg::CH_ZERO, 1'b0);
          n = $urandom_range(0, 4);
          for (int i = 0; i < n; i++) add_byte(name_filler(), 1'b0);
        end
        6: begin
          n = $urandom_range(0, key_len_of(k) - 1);
          for (int i = 0; i < n; i++) add_byte(key_letter(k, i), 1'b0);
        end
        7: begin
          for (int i = 0; i < key_len_of(k); i++) add_byte(key_letter(k, i), 1'b0);
          add_byte(name_filler(), 1'b0);
        end
        8: begin
          // long names around the name length limit
          n = $urandom_range(bkv_pkg::MAX_NAME_LEN - 4, bkv_pkg::MAX_NAME_LEN + 6);
          for (int i = 0; i < n; i++) add_byte(name_filler(), 1'b0);
        end
        9: begin
          // early close, then more name bytes before the real close
          for (int i = 0; i < key_len_of(k); i++) add_byte(key_letter(k, i), 1'b0);
          add_byte(bkv_pkg::CH_NAME_CLOSE, 1'b0);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) add_byte(name_filler(), 1'b0);
        end
        default: begin
          for (int i = 0; i < key_len_of(k); i++) add_byte(key_letter(k, i), 1'b0);
        end
      endcase
      add_byte(bkv_pkg::CH_NAME_CLOSE, 1'b0);
      if ($urandom_range(0, 3) == 0) add_byte("=", 1'b0);
      if ($urandom_range(0, 9) != 0) add_byte(bkv_pkg::CH_VALUE_OPEN, 1'b0);
      r = $urandom_range(0, 29);
      if (r == 0) n = $urandom_range(bkv_pkg::STAGE_LIMIT - 8, bkv_pkg::STAGE_LIMIT + 12);
      else if (r < 5) n = $urandom_range(20, 40);
      else n = $urandom_range(0, 16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 39) == 0) add_byte(bkv_pkg::CH_VALUE_OPEN, 1'b0);
        else add_byte(value_filler(), 1'b0);
      end
      r = $urandom_range(0, 9);
      if (r == 0) add_byte(bkv_pkg::CH_NAME_OPEN, 1'b0);  // cancel the pending value
      else if (r != 1) add_byte(bkv_pkg::CH_COMMIT, 1'b0);
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  // both channels sampled and driven at the rising edge
  always @(posedge clk) begin : traffic
    text_item_t           cur;
    bkv_pkg::bkv_result_t want;
    bit                   has_res;
    bit                   go;
    bit                   go_ready;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((text_chan.valid && text_chan.ready) || (result_chan.valid && result_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end

      // result transfer against the oldest expectation
      if (result_chan.valid && result_chan.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no result expected: kind %0d index %0d byte %0d",
                 result_chan.result_kind, result_chan.stage_index, result_chan.stage_byte);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", want.result_kind, result_chan.result_kind);
          check_field("stage_index", want.stage_index, result_chan.stage_index);
          check_field("stage_byte", want.stage_byte, result_chan.stage_byte);
          check_field("target_field", want.target_field, result_chan.target_field);
          check_field("commit_length", want.commit_length, result_chan.commit_length);
        end
      end

      // byte transfer: predict what it causes
      if (text_chan.valid && text_chan.ready) begin
        cur = stim[send_idx];
        parse_byte(cur.text_byte, cur.record_start, has_res, want);
        case (cur.check)
          CHK_NONE:  has_res = 1'b0;
          CHK_GIVEN: begin
            has_res = 1'b1;
            want    = cur.given;
          end
          default: ;
        endcase
        if (has_res) expected_results.push_back(want);
        send_idx++;
        if (burst_left > 0) burst_left--;
      end

      // sender: bursts with gaps, valid held until the transfer
      if (!(text_chan.valid && !text_chan.ready)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (send_idx >= stim.size()) begin
          go = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          go = 1'b0;
        end else if (stim[send_idx].hold && expected_results.size() != 0) begin
          go = 1'b0;
        end else begin
          go = 1'b1;
        end
        text_chan.valid <= go;
        if (go) begin
          text_chan.text_byte    <= stim[send_idx].text_byte;
          text_chan.record_start <= stim[send_idx].record_start;
        end
      end

      // receiver: stall pattern that changes every so often
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(16, 160);
      end else begin
        ready_left--;
      end
      case (ready_mode)
        0:       go_ready = 1'b1;
        1:       go_ready = ($urandom_range(0, 3) != 0);
        2:       go_ready = ($urandom_range(0, 3) == 0);
        default: begin
          go_ready = ((stall_phase % 7) < 4);
          stall_phase++;
        end
      endcase
      result_chan.ready <= go_ready;
    end
  end

  initial begin : run_ctrl
    bit timed_out;
    rst                    = 1'b1;
    text_chan.valid        = 1'b0;
    text_chan.text_byte    = 8'h00;
    text_chan.record_start = 1'b0;
    result_chan.ready      = 1'b0;
    clear_parse();

    for (int r = 0; r < DIRECTED_ROWS; r++) stim.push_back(DIRECTED[r]);
    while (stim.size() < DIRECTED_ROWS + RANDOM_ITEMS) add_record();
    // sender drains the parser before the random part and once within it
    stim[DIRECTED_ROWS].hold = 1'b1;
    stim[$urandom_range(DIRECTED_ROWS + 1, stim.size() - 1)].hold = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    timed_out = 1'b0;
    while (!timed_out && (send_idx < stim.size() || expected_results.size() != 0)) begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end

    if (timed_out) begin
      $display("CHECKS FAILED");
    end else begin
      // catch any late result nobody asked for
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (fail_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule
